// File: design/pce_pkg.sv
package pce_pkg;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic       scan_en;
    logic       gray_en;
    logic [7:0] brightness;
    logic [7:0] contrast;
  } cfg_t;

  typedef enum logic [1:0] {
    RegContrast   = 2'd0,
    RegBrightness = 2'd1,
    RegGray       = 2'd2,
    RegScan       = 2'd3
  } reg_idx_e;

  localparam logic [7:0]  ContrastRst = 8'd100;
  localparam logic [7:0]  BrightRst   = 8'd100;
  localparam logic [15:0] LumaR       = 16'd77;
  localparam logic [15:0] LumaG       = 16'd150;
  localparam logic [15:0] LumaB       = 16'd29;
  localparam logic [8:0]  MidLevel    = 9'd128;
  localparam logic [10:0] MidLevelW   = 11'd128;
  localparam logic [10:0] PercentW    = 11'd100;
  localparam logic [7:0]  ChanMax     = 8'd255;
  // floor(x / 100) == (x * 5243) >> 19 for every x below 2^15
  localparam logic [27:0] RecipMul    = 28'd5243;
  localparam int          RecipShift  = 19;

endpackage

// File: design/pce_regs.sv
module pce_regs import pce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.contrast   <= ContrastRst;
      cfg_q.brightness <= BrightRst;
      cfg_q.gray_en    <= 1'b0;
      cfg_q.scan_en    <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        RegContrast:   cfg_q.contrast   <= pwdata[7:0];
        RegBrightness: cfg_q.brightness <= pwdata[7:0];
        RegGray:       cfg_q.gray_en    <= pwdata[0];
        RegScan:       cfg_q.scan_en    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegContrast:   prdata = {24'd0, cfg_q.contrast};
      RegBrightness: prdata = {24'd0, cfg_q.brightness};
      RegGray:       prdata = {31'd0, cfg_q.gray_en};
      RegScan:       prdata = {31'd0, cfg_q.scan_en};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// File: design/pce_luma.sv
module pce_luma import pce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic gray_en_i,
  input  logic valid_i,
  output logic ready_o,
  input  rgb_t pix_i,
  input  logic even_i,
  output logic valid_o,
  input  logic ready_i,
  output rgb_t pix_o,
  output logic even_o
);

  logic        valid_q;
  rgb_t        pix_q, pix_d;
  logic        even_q;
  logic [15:0] luma_sum;

  assign luma_sum = {8'd0, pix_i.red} * LumaR + {8'd0, pix_i.green} * LumaG
                  + {8'd0, pix_i.blue} * LumaB;

  always_comb begin
    pix_d = pix_i;
    if (gray_en_i) begin
      pix_d.red   = luma_sum[15:8];
      pix_d.green = luma_sum[15:8];
      pix_d.blue  = luma_sum[15:8];
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign pix_o   = pix_q;
  assign even_o  = even_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q  <= pix_d;
      even_q <= even_i;
    end
  end

endmodule

// File: design/pce_contrast.sv
module pce_contrast import pce_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             contrast_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  rgb_t                   pix_i,
  input  logic                   even_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [2:0][9:0]        scaled_o,
  output logic                   even_o
);

  // first stage: magnitude of (c - 128) * contrast, sign kept aside
  logic              va_q;
  logic              even_a_q;
  logic [2:0]        neg_a_q, neg_a_d;
  logic [2:0][14:0]  mag_a_q, mag_a_d;
  logic              ready_a;

  // second stage: signed quotient by 100, truncated toward zero
  logic              vb_q;
  logic              even_b_q;
  logic [2:0][9:0]   scaled_b_q, scaled_b_d;
  logic              ready_b;

  logic [2:0][7:0]   ch;
  logic [2:0][8:0]   centered;
  logic [2:0][7:0]   cmag;
  logic [2:0][15:0]  prod;
  logic [2:0][27:0]  recip;
  logic [2:0][8:0]   quot;

  assign ch = pix_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      centered[i] = {1'b0, ch[i]} - MidLevel;
      neg_a_d[i]  = centered[i][8];
      cmag[i]     = centered[i][8] ? 8'(MidLevel - {1'b0, ch[i]}) : centered[i][7:0];
      prod[i]     = {8'd0, cmag[i]} * {8'd0, contrast_i};
      mag_a_d[i]  = prod[i][14:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      recip[i]      = {13'd0, mag_a_q[i]} * RecipMul;
      quot[i]       = recip[i][RecipShift +: 9];
      scaled_b_d[i] = neg_a_q[i] ? 10'(-{1'b0, quot[i]}) : {1'b0, quot[i]};
    end
  end

  assign ready_b  = !vb_q || ready_i;
  assign ready_a  = !va_q || ready_b;
  assign ready_o  = ready_a;
  assign valid_o  = vb_q;
  assign scaled_o = scaled_b_q;
  assign even_o   = even_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= valid_i;
      if (ready_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      neg_a_q  <= neg_a_d;
      mag_a_q  <= mag_a_d;
      even_a_q <= even_i;
    end
    if (ready_b && va_q) begin
      scaled_b_q <= scaled_b_d;
      even_b_q   <= even_a_q;
    end
  end

endmodule

// File: design/pce_level.sv
module pce_level import pce_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      brightness_i,
  input  logic            scan_en_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [2:0][9:0] scaled_i,
  input  logic            even_i,
  output logic            valid_o,
  input  logic            ready_i,
  output rgb_t            pix_o
);

  logic            valid_q;
  rgb_t            pix_q;
  logic [2:0][7:0] ch_d;
  logic [2:0][10:0] lvl;
  logic [2:0][7:0] sat;
  logic [2:0][9:0] dim;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lvl[i] = {scaled_i[i][9], scaled_i[i]} + MidLevelW + {3'd0, brightness_i} - PercentW;
      if (lvl[i][10]) begin
        sat[i] = 8'd0;
      end else if (lvl[i][9:8] != 2'd0) begin
        sat[i] = ChanMax;
      end else begin
        sat[i] = lvl[i][7:0];
      end
      // three quarters, rounded down
      dim[i]  = {2'd0, sat[i]} + {1'b0, sat[i], 1'b0};
      ch_d[i] = (scan_en_i && even_i) ? dim[i][9:2] : sat[i];
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign pix_o   = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pix_q <= rgb_t'(ch_d);
    end
  end

endmodule

// File: design/pixel_color_effects_top.sv
// Pixel color effects: grayscale, contrast/brightness, scanline darkening.
// Throughput: one pixel per cycle; four register stages, each holds its
// request until the next one frees, so a stall drops nothing.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets contrast and
// brightness to 100, grayscale and scanline off.
module pixel_color_effects_top import pce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
  input  logic        s_axis_tuser,  // row_is_even
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // red_out, green_out, blue_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t            cfg;
  logic            luma_valid, luma_ready, luma_even;
  rgb_t            luma_pix;
  logic            con_valid, con_ready, con_even;
  logic [2:0][9:0] con_scaled;
  rgb_t            out_pix;

  pce_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pce_luma u_luma (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .gray_en_i (cfg.gray_en),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .pix_i     (rgb_t'(s_axis_tdata)),
    .even_i    (s_axis_tuser),
    .valid_o   (luma_valid),
    .ready_i   (luma_ready),
    .pix_o     (luma_pix),
    .even_o    (luma_even)
  );

  pce_contrast u_contrast (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .contrast_i (cfg.contrast),
    .valid_i    (luma_valid),
    .ready_o    (luma_ready),
    .pix_i      (luma_pix),
    .even_i     (luma_even),
    .valid_o    (con_valid),
    .ready_i    (con_ready),
    .scaled_o   (con_scaled),
    .even_o     (con_even)
  );

  pce_level u_level (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .brightness_i (cfg.brightness),
    .scan_en_i    (cfg.scan_en),
    .valid_i      (con_valid),
    .ready_o      (con_ready),
    .scaled_i     (con_scaled),
    .even_i       (con_even),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .pix_o        (out_pix)
  );

  assign m_axis_tdata = out_pix;

endmodule

// File: dv/tb_pixel_color_effects_top.sv
module tb_pixel_color_effects_top;
  import pce_pkg::*;

  typedef struct {
    cfg_t       cfg;
    rgb_t       pix;
    logic       even;
    logic       typed;
    rgb_t       want;
  } pix_row_t;

  localparam cfg_t CfgNeutral = '{scan_en: 1'b0, gray_en: 1'b0,
                                  brightness: BrightRst, contrast: ContrastRst};
  localparam cfg_t CfgFlat    = '{scan_en: 1'b0, gray_en: 1'b0,
                                  brightness: 8'd100, contrast: 8'd0};
  localparam cfg_t CfgDark    = '{scan_en: 1'b0, gray_en: 1'b0,
                                  brightness: 8'd0, contrast: 8'd0};
  localparam cfg_t CfgBright  = '{scan_en: 1'b0, gray_en: 1'b0,
                                  brightness: 8'd255, contrast: 8'd100};
  localparam cfg_t CfgSteep   = '{scan_en: 1'b0, gray_en: 1'b0,
                                  brightness: 8'd100, contrast: 8'd255};
  localparam cfg_t CfgHigh    = '{scan_en: 1'b0, gray_en: 1'b0,
                                  brightness: 8'd0, contrast: 8'd200};
  localparam cfg_t CfgGray    = '{scan_en: 1'b0, gray_en: 1'b1,
                                  brightness: 8'd100, contrast: 8'd100};
  localparam cfg_t CfgScan    = '{scan_en: 1'b1, gray_en: 1'b0,
                                  brightness: 8'd100, contrast: 8'd100};
  localparam cfg_t CfgAll     = '{scan_en: 1'b1, gray_en: 1'b1,
                                  brightness: 8'd60, contrast: 8'd150};

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 155;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // red_in, green_in, blue_in
  logic        s_axis_tuser  = 1'b0;  // row_is_even
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // red_out, green_out, blue_out
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  cfg_t     cur_cfg = CfgNeutral;
  rgb_t     expected_pix[$];
  pix_row_t directed_rows[$];
  int       mismatches = 0;
  int       send_idle  = 0;
  int       recv_stall = 0;
  bit       hold_req   = 1'b0;
  int       hold_len   = 0;

  pixel_color_effects_top i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #800000;
    $display("pixel_color_effects_top test failed");
    $finish;
  end

  function automatic rgb_t predict_pixel(rgb_t pix, logic even, cfg_t cfg);
    int   lvl[3];
    int   luma;
    rgb_t res;
    lvl[0] = pix.red;
    lvl[1] = pix.green;
    lvl[2] = pix.blue;
    if (cfg.gray_en) begin
      luma = (int'(LumaR) * lvl[0] + int'(LumaG) * lvl[1] + int'(LumaB) * lvl[2]) >> 8;
      foreach (lvl[i]) lvl[i] = luma;
    end
    foreach (lvl[i]) begin
      // signed divide truncates toward zero
      lvl[i] = ((lvl[i] - int'(MidLevel)) * int'(cfg.contrast)) / int'(PercentW)
               + int'(MidLevel) + int'(cfg.brightness) - int'(PercentW);
      if (lvl[i] < 0) lvl[i] = 0;
      if (lvl[i] > int'(ChanMax)) lvl[i] = int'(ChanMax);
      if (cfg.scan_en && even) lvl[i] = (lvl[i] * 3) >> 2;
    end
    res.red   = lvl[0][7:0];
    res.green = lvl[1][7:0];
    res.blue  = lvl[2][7:0];
    return res;
  endfunction

  function automatic void add_row(cfg_t cfg, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                  logic even, logic typed,
                                  logic [7:0] wr = '0, logic [7:0] wg = '0,
                                  logic [7:0] wb = '0);
    pix_row_t row;
    row.cfg   = cfg;
    row.pix   = '{blue: b, green: g, red: r};
    row.even  = even;
    row.typed = typed;
    row.want  = '{blue: wb, green: wg, red: wr};
    directed_rows.push_back(row);
  endfunction

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(120, 136));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(rgb_t pix, logic even, logic typed, rgb_t want);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= even;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pix.push_back(typed ? want : predict_pixel(pix, even, cur_cfg));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_pix.size() != 0) @(posedge clk_i);
  endtask

  // leaves psel high so back-to-back writes never drop it within one step
  task automatic reg_write(reg_idx_e idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  // fill unused upper bits with noise; the block must mask them
  task automatic write_cfg(cfg_t cfg);
    logic [31:0] noise;
    noise = $urandom;
    reg_write(RegContrast, {noise[31:8], cfg.contrast});
    noise = $urandom;
    reg_write(RegBrightness, {noise[31:8], cfg.brightness});
    noise = $urandom;
    reg_write(RegGray, {noise[31:1], cfg.gray_en});
    noise = $urandom;
    reg_write(RegScan, {noise[31:1], cfg.scan_en});
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_cfg = cfg;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (hold_len) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  always @(posedge clk_i) begin
    rgb_t  got;
    rgb_t  want;
    string chan_name[3];
    chan_name = '{"red", "green", "blue"};
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = rgb_t'(m_axis_tdata);
      if (expected_pix.size() == 0) begin
        $display("%0t: unexpected pixel %h", $time, got);
        mismatches++;
      end else begin
        want = expected_pix.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got[8*i +: 8] !== want[8*i +: 8]) begin
            $display("%0t: %s expected %0d got %0d", $time, chan_name[i],
                     want[8*i +: 8], got[8*i +: 8]);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int   idle_send[4];
    int   idle_recv[4];
    cfg_t cfg;
    rgb_t pix;

    idle_send = '{0, 56, 0, 20};
    idle_recv = '{0, 0, 56, 20};

    // neutral settings pass the pixel through unchanged; then flat, dark and bright cases
    add_row(CfgNeutral, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0);
    add_row(CfgNeutral, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255);
    add_row(CfgNeutral, 8'd1, 8'd128, 8'd254, 1'b0, 1'b1, 8'd1, 8'd128, 8'd254);
    add_row(CfgNeutral, 8'h55, 8'haa, 8'h0f, 1'b1, 1'b1, 8'h55, 8'haa, 8'h0f);
    add_row(CfgFlat, 8'd0, 8'd255, 8'd77, 1'b0, 1'b1, 8'd128, 8'd128, 8'd128);
    add_row(CfgDark, 8'd255, 8'd0, 8'd128, 1'b1, 1'b1, 8'd28, 8'd28, 8'd28);
    add_row(CfgBright, 8'd0, 8'd255, 8'd100, 1'b0, 1'b1, 8'd155, 8'd255, 8'd255);
    // register values above 200 still saturate
    add_row(CfgSteep, 8'd0, 8'd255, 8'd128, 1'b1, 1'b1, 8'd0, 8'd255, 8'd128);
    add_row(CfgSteep, 8'd100, 8'd150, 8'd127, 1'b0, 1'b0);
    add_row(CfgHigh, 8'd0, 8'd255, 8'd140, 1'b0, 1'b0);
    add_row(CfgGray, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255);
    add_row(CfgGray, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0);
    add_row(CfgGray, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0);
    add_row(CfgGray, 8'd0, 8'd0, 8'd255, 1'b1, 1'b0);
    add_row(CfgScan, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd191, 8'd191, 8'd191);
    add_row(CfgScan, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255);
    add_row(CfgScan, 8'd4, 8'd5, 8'd6, 1'b1, 1'b0);
    add_row(CfgAll, 8'd200, 8'd100, 8'd50, 1'b1, 1'b0);
    add_row(CfgAll, 8'd17, 8'd230, 8'd90, 1'b0, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg != cur_cfg) begin
        drain_results();
        write_cfg(directed_rows[i].cfg);
      end
      send_pixel(directed_rows[i].pix, directed_rows[i].even,
                 directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      send_idle  = idle_send[ph % 4];
      recv_stall = idle_recv[ph % 4];
      case (ph)
        0:       cfg = '{scan_en: 1'b1, gray_en: 1'b0, brightness: 8'd100, contrast: 8'd100};
        1:       cfg = '{scan_en: 1'b0, gray_en: 1'b1, brightness: 8'd80, contrast: 8'd150};
        2:       cfg = '{scan_en: 1'b1, gray_en: 1'b1, brightness: 8'd255, contrast: 8'd0};
        3:       cfg = '{scan_en: 1'b0, gray_en: 1'b0, brightness: 8'd0, contrast: 8'd255};
        4:       cfg = '{scan_en: 1'b1, gray_en: 1'b0, brightness: 8'd200, contrast: 8'd200};
        default: cfg = '{scan_en: 1'($urandom), gray_en: 1'($urandom),
                         brightness: 8'($urandom_range(0, 255)),
                         contrast: 8'($urandom_range(0, 255))};
      endcase
      write_cfg(cfg);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // long receiver hold-off while the sender keeps pushing
        if (ph == 4 && n == 20) begin
          hold_len = $urandom_range(40, 80);
          hold_req = 1'b1;
        end
        pix = '{blue: rand_level(), green: rand_level(), red: rand_level()};
        send_pixel(pix, 1'($urandom), 1'b0, '0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("pixel_color_effects_top test passed");
    end else begin
      $display("pixel_color_effects_top test failed");
    end
    $finish;
  end

endmodule
